// ----- src/tgc_pkg.sv -----
`default_nettype none

package tgc_pkg;

    // Width of every type and canonical field on the ports
    localparam int unsigned FIELD_BITS = 8;
    localparam int unsigned KIND_BITS  = 5;
    localparam int unsigned COUNT_BITS = 3;

    // Default number of type bits that take part in the ordering
    localparam int unsigned TYPE_BITS_DEF = 8;

    // Largest graphlet size and the longest permutation list
    localparam int unsigned NODES     = 5;
    localparam int unsigned NUM_PERMS = 10;
    localparam int unsigned NUM_PSETS = 8;

    typedef struct packed {
        logic [KIND_BITS-1:0]  func;
        logic [FIELD_BITS-1:0] type_0;
        logic [FIELD_BITS-1:0] type_1;
        logic [FIELD_BITS-1:0] type_2;
        logic [FIELD_BITS-1:0] type_3;
        logic [FIELD_BITS-1:0] type_4;
    } item_t;

    typedef struct packed {
        logic [FIELD_BITS-1:0] canon_0;
        logic [FIELD_BITS-1:0] canon_1;
        logic [FIELD_BITS-1:0] canon_2;
        logic [FIELD_BITS-1:0] canon_3;
        logic [FIELD_BITS-1:0] canon_4;
        logic [COUNT_BITS-1:0] node_count;
        logic                  bad_kind;
    } result_t;

    // Graphlet kind codes
    typedef enum logic [KIND_BITS-1:0] {
        KIND_WEDGE           = 5'd0,
        KIND_TRIANGLE        = 5'd1,
        KIND_3_STAR          = 5'd2,
        KIND_3_PATH          = 5'd3,
        KIND_TAILED_TRI      = 5'd4,
        KIND_4_CYCLE         = 5'd5,
        KIND_DIAMOND         = 5'd6,
        KIND_4_CLIQUE        = 5'd7,
        KIND_4_STAR          = 5'd8,
        KIND_PRONG           = 5'd9,
        KIND_4_PATH          = 5'd10,
        KIND_FORKED_TAIL_TRI = 5'd11,
        KIND_LONG_TAIL_TRI   = 5'd12,
        KIND_DOUBLE_TAIL_TRI = 5'd13,
        KIND_TAILED_4_CYCLE  = 5'd14,
        KIND_5_CYCLE         = 5'd15,
        KIND_HOURGLASS       = 5'd16,
        KIND_COBRA           = 5'd17,
        KIND_STINGRAY        = 5'd18,
        KIND_HATTED_4_CYCLE  = 5'd19,
        KIND_3_WEDGE_COLL    = 5'd20,
        KIND_STELL_TRIDENT   = 5'd21,
        KIND_TAILED_4_CLIQUE = 5'd22,
        KIND_TRI_STRIP       = 5'd23,
        KIND_CHORD_WEDGE     = 5'd24,
        KIND_WHEEL           = 5'd25,
        KIND_HATTED_4_CLIQUE = 5'd26,
        KIND_ALMOST_5_CLIQUE = 5'd27,
        KIND_5_CLIQUE        = 5'd28
    } kind_t;

    // Node counts
    localparam logic [COUNT_BITS-1:0] COUNT_NONE  = 3'd0;
    localparam logic [COUNT_BITS-1:0] COUNT_THREE = 3'd3;
    localparam logic [COUNT_BITS-1:0] COUNT_FOUR  = 3'd4;
    localparam logic [COUNT_BITS-1:0] COUNT_FIVE  = 3'd5;

    // Permutation lists for the lexicographic minimum
    typedef enum logic [2:0] {
        PSET_REV4  = 3'd0,
        PSET_CYC4  = 3'd1,
        PSET_REV5  = 3'd2,
        PSET_DTT   = 3'd3,
        PSET_H4C   = 3'd4,
        PSET_CYC5  = 3'd5,
        PSET_WHEEL = 3'd6,
        PSET_STRIP = 3'd7
    } pset_t;

    typedef logic [2:0] idx_t;

    // Shorter lists are padded with the identity, which never changes the minimum
    localparam idx_t PERM_TABLE [NUM_PSETS][NUM_PERMS][NODES] = '{
        '{'{0,1,2,3,4}, '{3,2,1,0,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4},
          '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}},
        '{'{0,1,2,3,4}, '{1,2,3,0,4}, '{2,3,0,1,4}, '{3,0,1,2,4}, '{3,2,1,0,4},
          '{2,1,0,3,4}, '{1,0,3,2,4}, '{0,3,2,1,4}, '{0,1,2,3,4}, '{0,1,2,3,4}},
        '{'{0,1,2,3,4}, '{4,3,2,1,0}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4},
          '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}},
        '{'{0,1,2,3,4}, '{1,0,2,4,3}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4},
          '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}},
        '{'{0,1,2,3,4}, '{0,3,4,1,2}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4},
          '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}},
        '{'{0,1,2,3,4}, '{1,2,3,4,0}, '{2,3,4,0,1}, '{3,4,0,1,2}, '{4,0,1,2,3},
          '{4,3,2,1,0}, '{3,2,1,0,4}, '{2,1,0,4,3}, '{1,0,4,3,2}, '{0,4,3,2,1}},
        '{'{0,1,2,3,4}, '{0,2,3,4,1}, '{0,3,4,1,2}, '{0,4,1,2,3}, '{0,4,3,2,1},
          '{0,3,2,1,4}, '{0,2,1,4,3}, '{0,1,4,3,2}, '{0,1,2,3,4}, '{0,1,2,3,4}},
        '{'{0,1,2,3,4}, '{0,2,1,4,3}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4},
          '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}, '{0,1,2,3,4}}
    };

endpackage

`default_nettype wire

// ----- src/typed_graphlet_canonicalizer.sv -----
// Path: an accepted item passes through the input register and then the result register to the output.
// Throughput: one item per cycle while results are taken; the input and result registers advance together.
// The canonical tuple is formed by one pass of compare and select logic between them.
// A stalled result holds the result register, and the input register fills behind it.
// Reset (rst_n low, asynchronous) empties both registers; there is no other state.
`default_nettype none

module typed_graphlet_canonicalizer #(
    parameter int unsigned TYPE_BITS = tgc_pkg::TYPE_BITS_DEF
) (
    input  wire              clk,
    input  wire              rst_n,
    input  wire              item_valid,
    output logic             item_ready,
    input  tgc_pkg::item_t   item,
    output logic             result_valid,
    input  wire              result_ready,
    output tgc_pkg::result_t result
);
    import tgc_pkg::*;

    logic    item_v_reg;
    logic    item_v_next;
    item_t   item_reg;
    logic    res_v_reg;
    logic    res_v_next;
    result_t res_reg;
    result_t res_next;
    logic    adv_out;
    logic    adv_in;

    // Advance when the stage ahead is empty or is being drained
    assign adv_out    = !res_v_reg || result_ready;
    assign adv_in     = !item_v_reg || adv_out;
    assign item_ready = adv_in;

    assign item_v_next = adv_in ? item_valid : item_v_reg;
    assign res_v_next  = adv_out ? item_v_reg : res_v_reg;

    tgc_canon #(
        .TYPE_BITS (TYPE_BITS)
    ) u_canon (
        .item   (item_reg),
        .result (res_next)
    );

    // Hold the valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_v_reg <= 1'b0;
            res_v_reg  <= 1'b0;
        end
        else
        begin
            item_v_reg <= item_v_next;
            res_v_reg  <= res_v_next;
        end
    end

    // Capture the payloads on transfer
    always_ff @(posedge clk)
    begin
        if (adv_in && item_valid)
        begin
            item_reg <= item;
        end
        if (adv_out && item_v_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign result_valid = res_v_reg;
    assign result       = res_reg;

`ifndef SYNTH
    a_item_lands : assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> item_v_reg)
        else $error("accepted item did not reach the input register");

    a_stage_moves : assert property (@(posedge clk) disable iff (!rst_n)
        item_v_reg && adv_out |=> result_valid)
        else $error("staged item did not reach the result register");

    a_back_pressure : assert property (@(posedge clk) disable iff (!rst_n)
        item_v_reg && res_v_reg && !result_ready |-> !item_ready)
        else $error("input taken while both registers are full");

    a_bad_count : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.bad_kind == (result.node_count == COUNT_NONE)))
        else $error("bad kind flag disagrees with node count");

    a_unused_zero : assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.node_count != COUNT_FIVE |-> result.canon_4 == '0)
        else $error("unused slot is not zero");
`endif

endmodule

`default_nettype wire

// ----- src/tgc_canon.sv -----
`default_nettype none

module tgc_canon #(
    parameter int unsigned TYPE_BITS = tgc_pkg::TYPE_BITS_DEF
) (
    input  tgc_pkg::item_t   item,
    output tgc_pkg::result_t result
);
    import tgc_pkg::*;

    // Bits of each type that take part in the ordering
    localparam int unsigned W = (TYPE_BITS < FIELD_BITS) ? TYPE_BITS : FIELD_BITS;

    // Element 0 is the most significant, so a plain compare is lexicographic
    typedef logic [0:NODES-1][W-1:0] vec_t;

    // Compare and exchange two slots into ascending order
    function automatic vec_t cmpx(input vec_t v, input idx_t a, input idx_t b);
        vec_t r;
        r = v;
        if (v[a] > v[b])
        begin
            r[a] = v[b];
            r[b] = v[a];
        end
        return r;
    endfunction

    function automatic vec_t sort3(input vec_t v, input idx_t a, input idx_t b,
                                   input idx_t c);
        vec_t r;
        r = cmpx(v, a, b);
        r = cmpx(r, b, c);
        r = cmpx(r, a, b);
        return r;
    endfunction

    function automatic vec_t sort4(input vec_t v, input idx_t a, input idx_t b,
                                   input idx_t c, input idx_t d);
        vec_t r;
        r = cmpx(v, a, b);
        r = cmpx(r, c, d);
        r = cmpx(r, a, c);
        r = cmpx(r, b, d);
        r = cmpx(r, b, c);
        return r;
    endfunction

    function automatic vec_t sort5(input vec_t v);
        vec_t r;
        r = cmpx(v, 3'd0, 3'd1);
        r = cmpx(r, 3'd3, 3'd4);
        r = cmpx(r, 3'd2, 3'd4);
        r = cmpx(r, 3'd2, 3'd3);
        r = cmpx(r, 3'd1, 3'd4);
        r = cmpx(r, 3'd0, 3'd3);
        r = cmpx(r, 3'd0, 3'd2);
        r = cmpx(r, 3'd1, 3'd3);
        r = cmpx(r, 3'd1, 3'd2);
        return r;
    endfunction

    function automatic vec_t min_vec(input vec_t a, input vec_t b);
        return (b < a) ? b : a;
    endfunction

    // Lexicographic minimum over one permutation list, as a four-level tree
    function automatic vec_t lexmin(input vec_t v, input pset_t ps);
        vec_t cand [NUM_PERMS];
        vec_t lvl1 [5];
        vec_t lvl2a;
        vec_t lvl2b;
        for (int p = 0; p < NUM_PERMS; p++)
        begin
            for (int i = 0; i < NODES; i++)
            begin
                cand[p][i] = v[PERM_TABLE[ps][p][i]];
            end
        end
        for (int k = 0; k < 5; k++)
        begin
            lvl1[k] = min_vec(cand[2*k], cand[2*k+1]);
        end
        lvl2a = min_vec(lvl1[0], lvl1[1]);
        lvl2b = min_vec(lvl1[2], lvl1[3]);
        return min_vec(min_vec(lvl2a, lvl2b), lvl1[4]);
    endfunction

    vec_t                  t;
    vec_t                  v;
    logic [COUNT_BITS-1:0] n;
    logic                  bad;

    // Mask the types to the ordering width
    assign t[0] = item.type_0[W-1:0];
    assign t[1] = item.type_1[W-1:0];
    assign t[2] = item.type_2[W-1:0];
    assign t[3] = item.type_3[W-1:0];
    assign t[4] = item.type_4[W-1:0];

    // Apply the symmetry rule of the kind
    always_comb
    begin
        v   = t;
        n   = COUNT_FIVE;
        bad = 1'b0;
        case (kind_t'(item.func))
            KIND_WEDGE:
            begin
                n = COUNT_THREE;
                v = cmpx(t, 3'd1, 3'd2);
            end
            KIND_TRIANGLE:
            begin
                n = COUNT_THREE;
                v = sort3(t, 3'd0, 3'd1, 3'd2);
            end
            KIND_3_STAR:
            begin
                n = COUNT_FOUR;
                v = sort3(t, 3'd1, 3'd2, 3'd3);
            end
            KIND_3_PATH:
            begin
                n = COUNT_FOUR;
                v = lexmin(t, PSET_REV4);
            end
            KIND_TAILED_TRI:
            begin
                n = COUNT_FOUR;
                v = cmpx(t, 3'd2, 3'd3);
            end
            KIND_4_CYCLE:
            begin
                n = COUNT_FOUR;
                v = lexmin(t, PSET_CYC4);
            end
            KIND_DIAMOND:
            begin
                n = COUNT_FOUR;
                v = cmpx(cmpx(t, 3'd0, 3'd1), 3'd2, 3'd3);
            end
            KIND_4_CLIQUE:
            begin
                n = COUNT_FOUR;
                v = sort4(t, 3'd0, 3'd1, 3'd2, 3'd3);
            end
            KIND_4_STAR:
                v = sort4(t, 3'd1, 3'd2, 3'd3, 3'd4);
            KIND_PRONG, KIND_LONG_TAIL_TRI, KIND_STINGRAY:
                v = cmpx(t, 3'd3, 3'd4);
            KIND_4_PATH:
                v = lexmin(t, PSET_REV5);
            KIND_FORKED_TAIL_TRI, KIND_HATTED_4_CLIQUE:
                v = cmpx(cmpx(t, 3'd1, 3'd2), 3'd3, 3'd4);
            KIND_DOUBLE_TAIL_TRI:
                v = lexmin(t, PSET_DTT);
            KIND_TAILED_4_CYCLE, KIND_COBRA:
                v = cmpx(t, 3'd2, 3'd3);
            KIND_5_CYCLE:
                v = lexmin(t, PSET_CYC5);
            KIND_HOURGLASS:
            begin
                v = cmpx(cmpx(t, 3'd1, 3'd2), 3'd3, 3'd4);
                // Swap the two wings when the second one orders first
                if ({v[3], v[4]} < {v[1], v[2]})
                begin
                    v = {v[0], v[3], v[4], v[1], v[2]};
                end
            end
            KIND_HATTED_4_CYCLE:
                v = lexmin(t, PSET_H4C);
            KIND_3_WEDGE_COLL, KIND_STELL_TRIDENT, KIND_ALMOST_5_CLIQUE:
                v = sort3(cmpx(t, 3'd0, 3'd1), 3'd2, 3'd3, 3'd4);
            KIND_TAILED_4_CLIQUE:
                v = sort3(t, 3'd2, 3'd3, 3'd4);
            KIND_TRI_STRIP:
                v = lexmin(t, PSET_STRIP);
            KIND_CHORD_WEDGE:
            begin
                // Pair slot 1 with slot 3 and slot 2 with slot 4
                v = cmpx(cmpx(t, 3'd1, 3'd3), 3'd2, 3'd4);
            end
            KIND_WHEEL:
                v = lexmin(t, PSET_WHEEL);
            KIND_5_CLIQUE:
                v = sort5(t);
            default:
            begin
                n   = COUNT_NONE;
                bad = 1'b1;
            end
        endcase
    end

    // Zero the slots beyond the node count
    always_comb
    begin
        result.canon_0    = '0;
        result.canon_1    = '0;
        result.canon_2    = '0;
        result.canon_3    = '0;
        result.canon_4    = '0;
        result.node_count = n;
        result.bad_kind   = bad;
        if (!bad)
        begin
            result.canon_0 = FIELD_BITS'(v[0]);
            result.canon_1 = FIELD_BITS'(v[1]);
            result.canon_2 = FIELD_BITS'(v[2]);
        end
        if (n == COUNT_FOUR || n == COUNT_FIVE)
        begin
            result.canon_3 = FIELD_BITS'(v[3]);
        end
        if (n == COUNT_FIVE)
        begin
            result.canon_4 = FIELD_BITS'(v[4]);
        end
    end

endmodule

`default_nettype wire
